// File: sv/ots_pkg.sv
// ----------------------------------------------------------------------------
// ots_pkg
// Shared widths, constants and state types for the otsu threshold selector.
// ----------------------------------------------------------------------------
package ots_pkg;

    localparam int NumBins    = 256;
    localparam int BinAw      = 8;
    localparam int CntW       = 21;
    localparam int SumW       = 29;
    localparam int LimW       = 9;
    localparam int LimitReset = 150;
    localparam int LimitMin   = 2;
    localparam int LimitMax   = 256;
    localparam int MaxPixels  = 1048576;

    // difference of cross products, class product, square, full product
    localparam int DW     = CntW + SumW;
    localparam int PW     = 2 * CntW;
    localparam int SqW    = 2 * DW;
    localparam int ProdW  = SqW + DW;
    localparam int StepW  = $clog2(DW);

    localparam int CfgAw  = 3;
    localparam logic RegSearchLimit = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_RD,
        ST_ACC,
        ST_PA,
        ST_PB,
        ST_PP,
        ST_DIFF,
        ST_MS,
        ST_MW,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_SQ,
        PH_LHS,
        PH_RHS
    } t_phase;

endpackage

// File: sv/ots_ram.sv
// ----------------------------------------------------------------------------
// ots_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ots_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ots_sermul.sv
// ----------------------------------------------------------------------------
// ots_sermul
// Shift-add multiplier, one multiplier bit per cycle, for the score compare.
// ----------------------------------------------------------------------------
module ots_sermul import ots_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SqW-1:0]   i_mcand,
    input  logic [DW-1:0]    i_mplier,
    output logic             o_done,
    output logic [ProdW-1:0] o_product
);

    logic             r_busy;
    logic             r_done;
    logic [StepW-1:0] r_cnt;
    logic [ProdW-1:0] r_mc;
    logic [DW-1:0]    r_mp;
    logic [ProdW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= StepW'(DW - 1);
                r_mc   <= {{DW{1'b0}}, i_mcand};
                r_mp   <= i_mplier;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= {r_mc[ProdW-2:0], 1'b0};
                r_mp  <= {1'b0, r_mp[DW-1:1]};
                r_cnt <= r_cnt - StepW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: sv/otsu_threshold_select_top.sv
// intake: histogram update is a registered read-modify-write, one pixel per cycle
//   while idle; scan: each tested threshold runs three 50-step shift-add
//   multiplies in the score compare, plus states to drain and report
// no pixel is taken from the last pixel of a frame until its result is loaded
// reset: synchronous active low; clears histogram valid bits and totals,
//   search limit returns to 150
// ----------------------------------------------------------------------------
// otsu_threshold_select_top
// Gray histogram in RAM, then a per-frame Otsu threshold search.
// ----------------------------------------------------------------------------
module otsu_threshold_select_top import ots_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // pixel stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] gray_pixel
    input  logic             i_s_tlast,
    // result stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] threshold
    output logic             o_m_tuser,   // [0] no_split
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [CfgAw-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state r_state, n_state;
    t_phase r_phase;

    logic [LimW-1:0]    r_limit;
    logic [LimW-1:0]    lim_eff;
    logic [NumBins-1:0] r_valid;
    logic [CntW-1:0]    r_pix_total;
    logic [SumW-1:0]    r_gray_total;

    logic               r_s1_vld;
    logic [BinAw-1:0]   r_s1_addr;
    logic               r_wb_vld;
    logic [BinAw-1:0]   r_wb_addr;
    logic [CntW-1:0]    r_wb_data;
    logic [CntW-1:0]    wr_base;
    logic [CntW-1:0]    wr_data;

    logic [BinAw-1:0]   ram_raddr;
    logic [CntW-1:0]    ram_rdata;

    logic [LimW-1:0]    r_t;
    logic [CntW-1:0]    r_n0;
    logic [SumW-1:0]    r_s0;
    logic [DW-1:0]      r_a;
    logic [DW-1:0]      r_b;
    logic [PW-1:0]      r_p;
    logic [DW-1:0]      r_d;
    logic [SqW-1:0]     r_sq;
    logic [ProdW-1:0]   r_lhs;
    logic [SqW-1:0]     r_best_sq;
    logic [PW-1:0]      r_best_p;
    logic [BinAw-1:0]   r_best_t;
    logic               r_any;

    logic               r_out_vld;
    logic [7:0]         r_out_thr;
    logic               r_out_ns;

    logic               accept;
    logic               count_ok;
    logic               out_load;
    logic               cfg_wr;
    logic [CntW-1:0]    bin_val;
    logic [SumW-1:0]    acc_prod;
    logic [CntW-1:0]    n1;
    logic [SumW-1:0]    s1;
    logic [CntW-1:0]    mul_x;
    logic [SumW-1:0]    mul_y;
    logic [DW-1:0]      mul_p;
    logic [DW-1:0]      diff;

    logic               sm_start;
    logic               sm_done;
    logic [SqW-1:0]     sm_mcand;
    logic [DW-1:0]      sm_mplier;
    logic [ProdW-1:0]   sm_product;

    assign accept   = i_s_tvalid && o_s_tready;
    assign count_ok = r_pix_total < CntW'(MaxPixels);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (r_state == ST_DONE) && (!r_out_vld || i_m_tready);

    always_comb begin
        if (r_limit < LimW'(LimitMin)) begin
            lim_eff = LimW'(LimitMin);
        end else if (r_limit > LimW'(LimitMax)) begin
            lim_eff = LimW'(LimitMax);
        end else begin
            lim_eff = r_limit;
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegSearchLimit) ? {{(32-LimW){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimW'(LimitReset);
        end else if (cfg_wr && paddr[2] == RegSearchLimit) begin
            r_limit <= pwdata[LimW-1:0];
        end
    end

    // histogram memory and read-modify-write with one-deep forwarding
    assign ram_raddr = (r_state == ST_IDLE) ? i_s_tdata : r_t[BinAw-1:0];

    always_comb begin
        if (r_wb_vld && r_wb_addr == r_s1_addr) begin
            wr_base = r_wb_data;
        end else if (r_valid[r_s1_addr]) begin
            wr_base = ram_rdata;
        end else begin
            wr_base = '0;
        end
        wr_data = wr_base + CntW'(1);
    end

    ots_ram #(
        .WIDTH (CntW),
        .DEPTH (NumBins)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_wb_vld <= 1'b0;
        end else begin
            r_s1_vld  <= accept && count_ok;
            r_s1_addr <= i_s_tdata;
            r_wb_vld  <= r_s1_vld;
            r_wb_addr <= r_s1_addr;
            r_wb_data <= wr_data;
        end
    end

    // scan arithmetic
    assign bin_val  = r_valid[r_t[BinAw-1:0]] ? ram_rdata : '0;
    assign acc_prod = {{(SumW-BinAw){1'b0}}, r_t[BinAw-1:0]} * {{(SumW-CntW){1'b0}}, bin_val};
    assign n1       = r_pix_total - r_n0;
    assign s1       = r_gray_total - r_s0;

    always_comb begin
        case (r_state)
            ST_PA: begin
                mul_x = n1;
                mul_y = r_s0;
            end
            ST_PB: begin
                mul_x = r_n0;
                mul_y = s1;
            end
            default: begin
                mul_x = r_n0;
                mul_y = {{(SumW-CntW){1'b0}}, n1};
            end
        endcase
    end

    assign mul_p = {{SumW{1'b0}}, mul_x} * {{CntW{1'b0}}, mul_y};
    assign diff  = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);

    always_comb begin
        case (r_phase)
            PH_SQ: begin
                sm_mcand  = {{DW{1'b0}}, r_d};
                sm_mplier = r_d;
            end
            PH_LHS: begin
                sm_mcand  = r_sq;
                sm_mplier = {{(DW-PW){1'b0}}, r_best_p};
            end
            default: begin
                sm_mcand  = r_best_sq;
                sm_mplier = {{(DW-PW){1'b0}}, r_p};
            end
        endcase
    end

    assign sm_start = (r_state == ST_MS);

    ots_sermul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sm_start),
        .i_mcand   (sm_mcand),
        .i_mplier  (sm_mplier),
        .o_done    (sm_done),
        .o_product (sm_product)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (accept && i_s_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_RD;
            ST_RD:    n_state = ST_ACC;
            ST_ACC: begin
                n_state = (r_t == '0) ? ST_RD : ST_PA;
            end
            ST_PA:    n_state = ST_PB;
            ST_PB:    n_state = ST_PP;
            ST_PP:    n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_MS;
            ST_MS:    n_state = ST_MW;
            ST_MW: begin
                if (sm_done) begin
                    n_state = (r_phase == PH_RHS) ? ST_CMP : ST_MS;
                end
            end
            ST_CMP: begin
                n_state = ((r_t + LimW'(1)) == lim_eff) ? ST_DONE : ST_RD;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_pix_total  <= '0;
            r_gray_total <= '0;
            r_phase      <= PH_SQ;
            r_any        <= 1'b0;
        end else begin
            if (r_s1_vld) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && count_ok) begin
                        r_pix_total  <= r_pix_total + CntW'(1);
                        r_gray_total <= r_gray_total + {{(SumW-BinAw){1'b0}}, i_s_tdata};
                    end
                end
                ST_DRAIN: begin
                    r_t       <= '0;
                    r_n0      <= '0;
                    r_s0      <= '0;
                    r_best_sq <= '0;
                    r_best_p  <= PW'(1);
                    r_best_t  <= BinAw'(1);
                    r_any     <= 1'b0;
                end
                ST_ACC: begin
                    r_n0 <= r_n0 + bin_val;
                    r_s0 <= r_s0 + acc_prod;
                    if (r_t == '0) begin
                        r_t <= LimW'(1);
                    end
                end
                ST_PA: r_a <= mul_p;
                ST_PB: r_b <= mul_p;
                ST_PP: r_p <= mul_p[PW-1:0];
                ST_DIFF: begin
                    // empty class or balanced split scores zero
                    r_d     <= diff;
                    r_phase <= PH_SQ;
                    if (diff == '0) begin
                        r_p <= PW'(1);
                    end
                end
                ST_MW: begin
                    if (sm_done) begin
                        case (r_phase)
                            PH_SQ: begin
                                r_sq    <= sm_product[SqW-1:0];
                                r_phase <= PH_LHS;
                            end
                            PH_LHS: begin
                                r_lhs   <= sm_product;
                                r_phase <= PH_RHS;
                            end
                            default: r_phase <= PH_RHS;
                        endcase
                    end
                end
                ST_CMP: begin
                    // ties go to the later threshold
                    if (r_lhs >= sm_product) begin
                        r_best_sq <= r_sq;
                        r_best_p  <= r_p;
                        r_best_t  <= r_t[BinAw-1:0];
                    end
                    if (r_d != '0) begin
                        r_any <= 1'b1;
                    end
                    r_t <= r_t + LimW'(1);
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_valid      <= '0;
                        r_pix_total  <= '0;
                        r_gray_total <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
                r_out_thr <= r_best_t;
                r_out_ns  <= !r_any;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_thr;
    assign o_m_tuser  = r_out_ns;

`ifndef SYNTH
    a_wr_only_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == ST_IDLE || r_state == ST_DRAIN))
        else $error("histogram write outside pixel intake");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sm_done |-> (r_state == ST_MW))
        else $error("multiplier finished outside wait state");

    a_cleared_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_pix_total == '0 && r_valid == '0 && r_out_vld))
        else $error("statistics not cleared after result");

    a_no_intake_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MW) |-> (!o_s_tready && !r_s1_vld))
        else $error("pixel taken during scan");
`endif

endmodule

// File: tb/otsu_threshold_select_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otsu_threshold_select_top_tb
// Streams gray frames into the threshold selector, predicts each frame's Otsu
// threshold with exact wide-integer scoring and checks every reported result.
// Pixels and results idle at random; the search limit is changed between
// phases, out-of-range values included.
// ----------------------------------------------------------------------------
module otsu_threshold_select_top_tb import ots_pkg::*; ;

    localparam int WatchLimit = 200000;

    typedef struct packed {
        logic [7:0] gray;
        logic       last;
    } t_pix;

    typedef struct packed {
        logic [7:0] thr;
        logic       no_split;
    } t_split;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata = '0;
    logic             i_s_tlast = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [7:0]       o_m_tdata;
    logic             o_m_tuser;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [CfgAw-1:0] paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    otsu_threshold_select_top DUT (.*);

    t_pix   pixel_q[$];
    t_split split_q[$];

    // predictor state
    int unsigned     hist[NumBins];
    longint unsigned px_count;
    longint unsigned gray_sum;
    int unsigned     limit_reg;

    int  mismatches = 0;
    bit  quiet = 0;
    bit  s_took = 0;
    int  s_gap = 0;
    int  m_gap = 0;
    int  idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_split pick_threshold();
        int unsigned     lim;
        longint unsigned n0, s0, n1, s1, a, b, d, p, best_d, best_p;
        logic [191:0]    lhs, rhs;
        t_split          r;
        bit              any;
        lim = limit_reg;
        if (lim < LimitMin) lim = LimitMin;
        if (lim > LimitMax) lim = LimitMax;
        n0 = hist[0];
        s0 = 0;
        best_d = 0;
        best_p = 1;
        r.thr = 8'd1;
        any = 0;
        for (int t = 1; t < lim; t++) begin
            n0 += hist[t];
            s0 += longint'(t) * hist[t];
            n1 = px_count - n0;
            s1 = gray_sum - s0;
            if (n0 == 0 || n1 == 0) begin
                d = 0;
                p = 1;
            end else begin
                a = n1 * s0;
                b = n0 * s1;
                d = (a >= b) ? a - b : b - a;
                p = (d == 0) ? 1 : n0 * n1;
            end
            lhs = 192'(d) * 192'(d) * 192'(best_p);
            rhs = 192'(best_d) * 192'(best_d) * 192'(p);
            if (lhs >= rhs) begin
                best_d = d;
                best_p = p;
                r.thr = t[7:0];
            end
            if (d != 0) any = 1;
        end
        r.no_split = !any;
        return r;
    endfunction

    // monitor: predictor on accepted pixels, compare on accepted results
    always @(posedge i_clk) begin
        t_split e;
        s_took <= i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                if (px_count < MaxPixels) begin
                    hist[i_s_tdata]++;
                    px_count++;
                    gray_sum += i_s_tdata;
                end
                if (i_s_tlast) begin
                    split_q = {split_q, pick_threshold()};
                    foreach (hist[k]) hist[k] = 0;
                    px_count = 0;
                    gray_sum = 0;
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (split_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result thr=%0d no_split=%0b",
                                 o_m_tdata, o_m_tuser);
                end else begin
                    e = split_q.pop_front();
                    if (e.thr !== o_m_tdata || e.no_split !== o_m_tuser) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected thr=%0d no_split=%0b, ",
                                      "got thr=%0d no_split=%0b"},
                                     e.thr, e.no_split, o_m_tdata, o_m_tuser);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WatchLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // pixel driver
    always @(negedge i_clk) begin
        logic nv;
        t_pix cur;
        nv = i_s_tvalid;
        if (i_s_tvalid && s_took) nv = 1'b0;
        if (!nv && i_rst_n) begin
            if (s_gap > 0) begin
                s_gap--;
            end else if (pixel_q.size() > 0) begin
                cur = pixel_q.pop_front();
                i_s_tdata <= cur.gray;
                i_s_tlast <= cur.last;
                nv = 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) s_gap = $urandom_range(1, 15);
            end
        end
        i_s_tvalid <= nv;
    end

    // result ready driver
    always @(negedge i_clk) begin
        if (m_gap > 0) begin
            m_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) m_gap = $urandom_range(1, 15);
        end
    end

    task automatic cfg_write(input logic [CfgAw-1:0] addr, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[CfgAw-1:2] == RegSearchLimit) limit_reg = 32'(val[LimW-1:0]);
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || i_s_tvalid || split_q.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // mode 0 uniform, 1 two clusters, 2 constant, 3 two given levels
    task automatic add_frame(input int len, input int mode,
                             input int va = 0, input int vb = 255);
        t_pix p;
        int   c0, c1;
        c0 = $urandom_range(0, 255);
        c1 = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: p.gray = 8'($urandom_range(0, 255));
                1: begin
                    p.gray = 8'(($urandom_range(0, 1) ? c0 : c1) + $urandom_range(0, 6));
                end
                2: p.gray = 8'(c0);
                default: p.gray = 8'((i % 2) ? vb : va);
            endcase
            p.last = (i == len - 1);
            pixel_q = {pixel_q, p};
        end
    endtask

    initial begin
        int unsigned lim;
        foreach (hist[k]) hist[k] = 0;
        px_count = 0;
        gray_sum = 0;
        limit_reg = LimitReset;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit: lone pixels, tie, extremes
        add_frame(1, 3, 0, 0);
        add_frame(1, 3, 255, 255);
        add_frame(2, 3, 0, 3);
        add_frame(2, 3, 0, 255);
        add_frame(6, 1);
        wait_idle();

        cfg_write(0, 32'd256);
        add_frame(4, 3, 255, 255);
        add_frame(3, 3, 0, 255);
        wait_idle();

        cfg_write(0, 32'd0);
        add_frame(2, 3, 0, 1);
        add_frame(2, 3, 5, 200);
        wait_idle();
        cfg_write(0, 32'd1);
        add_frame(3, 3, 1, 0);
        wait_idle();
        cfg_write(0, 32'hFFFF_FFFF);
        add_frame(8, 0);
        wait_idle();
        cfg_write(0, 32'h8000_0010);
        cfg_write(4, 32'd3);  // not a register, ignored
        add_frame(5, 3, 2, 30);
        wait_idle();

        // random phases, small limits (but for one phase) keep the scans short
        for (int ph = 0; ph < 6; ph++) begin
            lim = (ph == 2) ? $urandom_range(0, 511) : $urandom_range(2, 40);
            cfg_write(0, {23'($urandom_range(0, 8388607)), lim[8:0]});
            if (ph == 5) quiet = 1;
            while (pixel_q.size() < 330)
                add_frame($urandom_range(1, 60), $urandom_range(0, 3),
                          $urandom_range(0, 255), $urandom_range(0, 255));
            wait_idle();
        end

        if (mismatches == 0 && split_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/ots_pkg.sv
sv/ots_ram.sv
sv/ots_sermul.sv
sv/otsu_threshold_select_top.sv
tb/otsu_threshold_select_top_tb.sv
